FILE: design/tevq_pkg.sv
// ----------------------------------------------------------------------------
// Timer event queue package
// Command codes, row kinds, table operations and the control/status bundles
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tevq_pkg;

   // Input command codes.
   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_SCHEDULE = 2'd1;
   localparam logic [1:0] CMD_CANCEL   = 2'd2;

   // Widths of the transaction fields.
   localparam int unsigned TIME_W  = 64;
   localparam int unsigned PROC_W  = 8;
   localparam int unsigned MSG_W   = 32;
   localparam int unsigned STEP_W  = 20;
   localparam int unsigned CNT_W   = 6;

   // Most fired events reported by one tick.
   localparam logic [CNT_W-1:0] MAX_ROWS = 6'd32;
   // Saturation value of the cancel count.
   localparam logic [CNT_W-1:0] CNT_SAT  = 6'd63;
   // Tick step after reset: 1000000 us / 100 ticks per second.
   localparam logic [STEP_W-1:0] STEP_RESET = 20'd10000;

   // Which result row the datapath loads into the output register.
   typedef enum logic [2:0] {
      ROW_NONE,
      ROW_EMPTY,
      ROW_FULL,
      ROW_CANCEL,
      ROW_FIRED
   } row_kind_type;

   // What the event table does in a cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP,
      OP_ROTATE
   } table_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic         accept;
      table_op_type op;
      row_kind_type row;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic due;
      logic full;
      logic rotating;
      logic last;
   } dp_status_type;

endpackage

FILE: design/tevq_datapath.sv
// ----------------------------------------------------------------------------
// Timer event queue datapath
// Holds the clock, the tick step, the sorted event table and the result
// register, and carries out the table operations the controller requests.
// ----------------------------------------------------------------------------
module tevq_datapath #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tevq_pkg::STEP_W-1:0]    csr_write_data,
   input  logic [1:0]                     req_command,
   input  logic [tevq_pkg::PROC_W-1:0]    req_process_id,
   input  logic [tevq_pkg::TIME_W-1:0]    req_trigger_time_us,
   input  logic [tevq_pkg::MSG_W-1:0]     req_message_tag,
   input  tevq_pkg::dp_cmd_type           cmd,
   output tevq_pkg::dp_status_type        status,
   output logic                           rsp_fired,
   output logic [tevq_pkg::PROC_W-1:0]    rsp_fired_process,
   output logic [tevq_pkg::MSG_W-1:0]     rsp_fired_message,
   output logic                           rsp_status,
   output logic [tevq_pkg::CNT_W-1:0]     rsp_cancelled_count,
   output logic [tevq_pkg::TIME_W-1:0]    rsp_now_us,
   output logic                           rsp_last
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [tevq_pkg::STEP_W-1:0] step_ff;
   logic [tevq_pkg::TIME_W-1:0] clock_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               steps_ff;
   logic [tevq_pkg::CNT_W-1:0]  rows_ff, removed_ff;
   logic [tevq_pkg::PROC_W-1:0] pid_ff;
   logic [tevq_pkg::TIME_W-1:0] trig_ff;
   logic [tevq_pkg::MSG_W-1:0]  mesg_ff;

   logic [tevq_pkg::TIME_W-1:0] time_ff [QUEUE_DEPTH];
   logic [tevq_pkg::PROC_W-1:0] proc_ff [QUEUE_DEPTH];
   logic [tevq_pkg::MSG_W-1:0]  msg_ff  [QUEUE_DEPTH];
   logic [tevq_pkg::TIME_W-1:0] time_in [QUEUE_DEPTH];
   logic [tevq_pkg::PROC_W-1:0] proc_in [QUEUE_DEPTH];
   logic [tevq_pkg::MSG_W-1:0]  msg_in  [QUEUE_DEPTH];

   logic [QUEUE_DEPTH-1:0] lt, lt_prev;
   logic [IW-1:0]          tail_idx;
   logic                   keep_head, due, next_due, full;

   // Per-entry compares and shifted neighbors for the table operations.
   always_comb begin
      full      = (count_ff == CW'(QUEUE_DEPTH));
      keep_head = (proc_ff[0] != pid_ff);
      tail_idx  = IW'(count_ff - CW'(1));
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         lt[i] = (CW'(i) < count_ff) && (time_ff[i] < trig_ff);
      end
      lt_prev[0] = 1'b1;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
         lt_prev[i] = lt[i-1];
      end
      due      = (count_ff != '0) && (time_ff[0] <= clock_ff) &&
                 (rows_ff < tevq_pkg::MAX_ROWS);
      next_due = (count_ff > CW'(1)) && (time_ff[1] <= clock_ff) &&
                 (rows_ff < tevq_pkg::MAX_ROWS - 6'd1);
   end

   // Next contents of every table entry.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         time_in[i] = time_ff[i];
         proc_in[i] = proc_ff[i];
         msg_in[i]  = msg_ff[i];
      end
      case (cmd.op)
         tevq_pkg::OP_INSERT: begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               if (!lt[i] && lt_prev[i]) begin
                  time_in[i] = trig_ff;
                  proc_in[i] = pid_ff;
                  msg_in[i]  = mesg_ff;
               end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
               if (!lt[i] && !lt_prev[i]) begin
                  time_in[i] = time_ff[i-1];
                  proc_in[i] = proc_ff[i-1];
                  msg_in[i]  = msg_ff[i-1];
               end
            end
         end
         tevq_pkg::OP_POP, tevq_pkg::OP_ROTATE: begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
               time_in[i] = time_ff[i+1];
               proc_in[i] = proc_ff[i+1];
               msg_in[i]  = msg_ff[i+1];
            end
            // A kept head goes to the tail of the valid region.
            if (cmd.op == tevq_pkg::OP_ROTATE && keep_head) begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (IW'(i) == tail_idx) begin
                     time_in[i] = time_ff[0];
                     proc_in[i] = proc_ff[0];
                     msg_in[i]  = msg_ff[0];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Fill count follows the table operation.
   always_comb begin
      case (cmd.op)
         tevq_pkg::OP_INSERT: count_in = count_ff + CW'(1);
         tevq_pkg::OP_POP:    count_in = count_ff - CW'(1);
         tevq_pkg::OP_ROTATE: count_in = keep_head ? count_ff : count_ff - CW'(1);
         default:             count_in = count_ff;
      endcase
   end

   // Table storage.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         time_ff[i] <= time_in[i];
         proc_ff[i] <= proc_in[i];
         msg_ff[i]  <= msg_in[i];
      end
   end

   // Control state: step, clock, count and per-transaction counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= tevq_pkg::STEP_RESET;
         clock_ff   <= '0;
         count_ff   <= '0;
         steps_ff   <= '0;
         rows_ff    <= '0;
         removed_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         count_ff <= count_in;
         if (cmd.accept) begin
            rows_ff    <= '0;
            removed_ff <= '0;
            steps_ff   <= count_ff;
            if (req_command == tevq_pkg::CMD_TICK) begin
               clock_ff <= clock_ff + tevq_pkg::TIME_W'(step_ff);
            end
         end
         if (cmd.op == tevq_pkg::OP_POP) begin
            rows_ff <= rows_ff + 6'd1;
         end
         if (cmd.op == tevq_pkg::OP_ROTATE) begin
            steps_ff <= steps_ff - CW'(1);
            if (!keep_head && removed_ff != tevq_pkg::CNT_SAT) begin
               removed_ff <= removed_ff + 6'd1;
            end
         end
      end
   end

   // Latched request fields.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pid_ff  <= req_process_id;
         trig_ff <= req_trigger_time_us;
         mesg_ff <= req_message_tag;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.row != tevq_pkg::ROW_NONE) begin
         rsp_now_us          <= clock_ff;
         rsp_fired           <= 1'b0;
         rsp_fired_process   <= '0;
         rsp_fired_message   <= '0;
         rsp_status          <= 1'b0;
         rsp_cancelled_count <= '0;
         rsp_last            <= 1'b1;
         case (cmd.row)
            tevq_pkg::ROW_FIRED: begin
               rsp_fired         <= 1'b1;
               rsp_fired_process <= proc_ff[0];
               rsp_fired_message <= msg_ff[0];
               rsp_last          <= !next_due;
            end
            tevq_pkg::ROW_FULL:   rsp_status          <= 1'b1;
            tevq_pkg::ROW_CANCEL: rsp_cancelled_count <= removed_ff;
            default: begin
            end
         endcase
      end
   end

   assign status.due       = due;
   assign status.full      = full;
   assign status.rotating  = (steps_ff != '0);
   assign status.last      = rsp_last;

endmodule

FILE: design/tevq_controller.sv
// ----------------------------------------------------------------------------
// Timer event queue controller
// Sequences one transaction at a time: accept, table work, result delivery.
// ----------------------------------------------------------------------------
module tevq_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_command,
   input  logic                     rsp_ready,
   input  tevq_pkg::dp_status_type  status,
   output tevq_pkg::dp_cmd_type     cmd,
   output logic                     req_ready,
   output logic                     rsp_valid
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_SCAN,
      S_CANCEL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.op     = tevq_pkg::OP_HOLD;
      cmd.row    = tevq_pkg::ROW_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.accept = 1'b1;
               case (req_command)
                  tevq_pkg::CMD_TICK:     state_in = S_SCAN;
                  tevq_pkg::CMD_SCHEDULE: state_in = S_INSERT;
                  tevq_pkg::CMD_CANCEL:   state_in = S_CANCEL;
                  default: begin
                     cmd.row  = tevq_pkg::ROW_EMPTY;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_INSERT: begin
            if (status.full) begin
               cmd.row = tevq_pkg::ROW_FULL;
            end else begin
               cmd.op  = tevq_pkg::OP_INSERT;
               cmd.row = tevq_pkg::ROW_EMPTY;
            end
            state_in = S_OUT;
         end
         S_SCAN: begin
            if (status.due) begin
               cmd.op  = tevq_pkg::OP_POP;
               cmd.row = tevq_pkg::ROW_FIRED;
            end else begin
               cmd.row = tevq_pkg::ROW_EMPTY;
            end
            state_in = S_OUT;
         end
         S_CANCEL: begin
            if (status.rotating) begin
               cmd.op = tevq_pkg::OP_ROTATE;
            end else begin
               cmd.row  = tevq_pkg::ROW_CANCEL;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = status.last ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/timer_event_queue_core.sv
// A schedule passes the insert state before its row; a cancel examines one
// table entry per cycle before its count row; the unused command code gives its
// row from idle. A tick's first row follows the scan state, then scan and result
// states alternate while the consumer is ready; the next request is taken the
// cycle after the final row is accepted, set by the single controller sequence.
// Reset clears the clock, the fill count and the step (to 10000); no sweep.
// ----------------------------------------------------------------------------
// Timer event queue core
// Sorted table of pending timer events with schedule, cancel and tick.
// ----------------------------------------------------------------------------
module timer_event_queue_core #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [tevq_pkg::STEP_W-1:0]    csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_command,
   input  logic [tevq_pkg::PROC_W-1:0]    req_process_id,
   input  logic [tevq_pkg::TIME_W-1:0]    req_trigger_time_us,
   input  logic [tevq_pkg::MSG_W-1:0]     req_message_tag,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_fired,
   output logic [tevq_pkg::PROC_W-1:0]    rsp_fired_process,
   output logic [tevq_pkg::MSG_W-1:0]     rsp_fired_message,
   output logic                           rsp_status,
   output logic [tevq_pkg::CNT_W-1:0]     rsp_cancelled_count,
   output logic [tevq_pkg::TIME_W-1:0]    rsp_now_us,
   output logic                           rsp_last
);

   tevq_pkg::dp_cmd_type    cmd;
   tevq_pkg::dp_status_type status;

   // Control sequencer.
   tevq_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid)
   );

   // Table, clock and result register.
   tevq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_command         (req_command),
      .req_process_id      (req_process_id),
      .req_trigger_time_us (req_trigger_time_us),
      .req_message_tag     (req_message_tag),
      .cmd                 (cmd),
      .status              (status),
      .rsp_fired           (rsp_fired),
      .rsp_fired_process   (rsp_fired_process),
      .rsp_fired_message   (rsp_fired_message),
      .rsp_status          (rsp_status),
      .rsp_cancelled_count (rsp_cancelled_count),
      .rsp_now_us          (rsp_now_us),
      .rsp_last            (rsp_last)
   );

endmodule

FILE: design/tevq_checker.sv
// ----------------------------------------------------------------------------
// Timer event queue checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module tevq_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_fired,
   input logic                        rsp_status,
   input logic [tevq_pkg::CNT_W-1:0]  rsp_cancelled_count,
   input logic                        rsp_last
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // No new transaction is taken while a result is on offer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request accepted while a result is pending");

   // A row without a fired event ends its transaction.
   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last)
      else $error("non-fired row not marked last");

   // Fired rows carry no status or cancel count.
   a_fired_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> !rsp_status && rsp_cancelled_count == '0)
      else $error("fired row carries status or count");

endmodule

bind timer_event_queue_core tevq_checker u_tevq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_fired           (rsp_fired),
   .rsp_status          (rsp_status),
   .rsp_cancelled_count (rsp_cancelled_count),
   .rsp_last            (rsp_last)
);
